FILE: src/sfcp_pkg.sv
// ----------------------------------------------------------------------------
// sfcp_pkg
// shared types and constants for the sensor frame checksum parser
// ----------------------------------------------------------------------------
package sfcp_pkg;

    localparam logic [7:0] START_BYTE  = 8'h42;
    localparam int         STORE_DEPTH = 14;
    localparam int         IDX_W       = 4;
    localparam int         WORD_W      = 16;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_COLLECT,
        ST_READ,
        ST_SHOW
    } t_state;

    // controls for the shared sum / compare unit
    typedef struct packed {
        logic start;
        logic add;
        logic check;
    } t_sum_ctl;

endpackage

FILE: src/sfcp_sum_unit.sv
// ----------------------------------------------------------------------------
// sfcp_sum_unit
// 16-bit wrapping byte sum with checksum compare
// ----------------------------------------------------------------------------
module sfcp_sum_unit
    import sfcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sum_ctl          i_ctl,
    input  logic [7:0]        i_byte,
    input  logic [WORD_W-1:0] i_received,
    output logic              o_ok
);

    logic [WORD_W-1:0] r_sum;
    logic [WORD_W-1:0] n_sum;
    logic              r_ok;
    logic              n_ok;

    always_comb begin
        n_sum = r_sum;
        n_ok  = r_ok;
        if (i_ctl.start) begin
            n_sum = {{(WORD_W-8){1'b0}}, START_BYTE};
        end else if (i_ctl.add) begin
            n_sum = r_sum + {{(WORD_W-8){1'b0}}, i_byte};
        end else if (i_ctl.check) begin
            n_ok  = (r_sum == i_received);
            n_sum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_ok  <= 1'b0;
        end else begin
            r_sum <= n_sum;
            r_ok  <= n_ok;
        end
    end

    assign o_ok = r_ok;

endmodule

FILE: src/sfcp_word_store.sv
// ----------------------------------------------------------------------------
// sfcp_word_store
// frame word memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module sfcp_word_store
    import sfcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [STORE_DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/sensor_frame_checksum_parser_unit.sv
// ----------------------------------------------------------------------------
// sensor_frame_checksum_parser_unit
// byte-serial particulate sensor frame parser with checksum check
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall carry one received byte (i_rx_byte)
//   output channel: o_valid / i_stall carry one frame word with its index,
//   the checksum verdict and a last-word flag
//   while hunting, every byte other than the start byte is dropped; the
//   start byte opens a frame of FRAME_BYTES bytes
//   during a frame one byte is taken every cycle (each byte but the
//   high checksum byte passes through the shared sum unit); the second byte is summed but never checked
//   on the last byte the checksum is compared and the block raises o_stall
//   while it plays out the stored words from the word memory
//   each word goes through a memory read (ST_READ), then presentation
//   (ST_SHOW), which lasts as long as the receiver holds i_stall; no new
//   byte is taken until the last word of the frame has been taken
//   a stalled word holds its payload until it is taken
//   reset (synchronous, active low) returns the block to hunting with an
//   empty sum; the word memory is not cleared, every word is written in
//   the frame before it is read
// ----------------------------------------------------------------------------
module sensor_frame_checksum_parser_unit
    import sfcp_pkg::*;
#(
    parameter int FRAME_BYTES = 32
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [IDX_W-1:0]  o_word_index,
    output logic [WORD_W-1:0] o_word_value,
    output logic              o_checksum_ok,
    output logic              o_last_word
);

    // position counter and an extended copy with headroom for compares
    localparam int PW         = $clog2(FRAME_BYTES);
    localparam int XW         = PW + 1;
    localparam int RAW_WORDS  = (FRAME_BYTES - 4) / 2;
    localparam int WORD_COUNT = (RAW_WORDS < STORE_DEPTH) ? RAW_WORDS : STORE_DEPTH;

    localparam logic [XW-1:0]    FB_X      = XW'(FRAME_BYTES);
    localparam logic [XW-1:0]    LAST_X    = XW'(FRAME_BYTES - 1);
    localparam logic [XW-1:0]    DEPTH_X   = XW'(STORE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_WIDX = IDX_W'(WORD_COUNT - 1);

    t_state            r_state;
    t_state            n_state;
    logic [PW-1:0]     r_pos;
    logic [7:0]        r_hold;
    logic [IDX_W-1:0]  r_widx;

    logic              w_in_acc;
    logic              w_out_acc;
    logic [XW-1:0]     w_p;
    logic [XW-1:0]     w_k;
    logic              w_in_data;
    logic              w_high_half;
    logic              w_last_byte;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [WORD_W-1:0] w_rd_data;
    logic              w_ok;
    t_sum_ctl          w_sum_ctl;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    // byte position decode
    assign w_p         = XW'(r_pos);
    assign w_k         = (w_p - XW'(3)) >> 1;
    assign w_in_data   = (w_p >= XW'(2)) && ((w_p + XW'(3)) <= FB_X);
    assign w_high_half = !w_p[0];     // (p - 2) even
    assign w_last_byte = (w_p == LAST_X);

    // data word write: low byte of a pair, within store depth
    assign w_wr_en = (r_state == ST_COLLECT) && w_in_acc && w_in_data
                     && !w_high_half && (w_k < DEPTH_X);

    // shared sum unit control
    always_comb begin
        w_sum_ctl       = '0;
        w_sum_ctl.start = (r_state == ST_HUNT) && w_in_acc && (i_rx_byte == START_BYTE);
        w_sum_ctl.add   = (r_state == ST_COLLECT) && w_in_acc && ((w_p + XW'(2)) < FB_X);
        w_sum_ctl.check = (r_state == ST_COLLECT) && w_in_acc && w_last_byte;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_HUNT: begin
                if (w_in_acc && (i_rx_byte == START_BYTE)) begin
                    n_state = ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                if (w_in_acc && w_last_byte) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (w_out_acc) begin
                    n_state = (r_widx == LAST_WIDX) ? ST_HUNT : ST_READ;
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // handshake outputs
    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        w_rd_en = 1'b0;
        case (r_state)
            ST_HUNT:    o_stall = 1'b0;
            ST_COLLECT: o_stall = 1'b0;
            ST_READ:    w_rd_en = 1'b1;
            ST_SHOW:    o_valid = 1'b1;
            default:    o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_pos   <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_HUNT) && w_in_acc && (i_rx_byte == START_BYTE)) begin
                r_pos <= PW'(1);
            end else if ((r_state == ST_COLLECT) && w_in_acc) begin
                r_pos <= w_last_byte ? '0 : r_pos + PW'(1);
            end
            if ((r_state == ST_COLLECT) && w_in_acc && w_last_byte) begin
                r_widx <= '0;
            end else if ((r_state == ST_SHOW) && w_out_acc) begin
                r_widx <= r_widx + IDX_W'(1);
            end
        end
    end

    // high byte of a data pair or of the received checksum
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_COLLECT) && w_in_acc) begin
            if ((w_in_data && w_high_half) || ((w_p + XW'(2)) == FB_X)) begin
                r_hold <= i_rx_byte;
            end
        end
    end

    sfcp_sum_unit u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_sum_ctl),
        .i_byte     (i_rx_byte),
        .i_received ({r_hold, i_rx_byte}),
        .o_ok       (w_ok)
    );

    sfcp_word_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_k[IDX_W-1:0]),
        .i_wr_data ({r_hold, i_rx_byte}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_widx),
        .o_rd_data (w_rd_data)
    );

    assign o_word_index  = r_widx;
    assign o_word_value  = w_rd_data;
    assign o_checksum_ok = w_ok;
    assign o_last_word   = (r_widx == LAST_WIDX);

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sensor frame checksum parser: byte streams with
// noise, well-formed and damaged frames are sent, each frame word coming out
// is checked against a frame decoder kept inside the bench
// ----------------------------------------------------------------------------
module tb;
    import sfcp_pkg::*;

    localparam int FRAME_BYTES = 32;
    // words played out per frame: (bytes - start pair - checksum pair) / 2, capped
    localparam int WORD_COUNT  = ((FRAME_BYTES - 4) / 2 < STORE_DEPTH) ?
                                 (FRAME_BYTES - 4) / 2 : STORE_DEPTH;
    localparam logic [7:0] SECOND_BYTE = 8'h4D;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] value;
        logic              sum_ok;
        logic              last;
    } t_frame_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_rx_byte;
    logic              o_valid;
    logic              i_stall;
    logic [IDX_W-1:0]  o_word_index;
    logic [WORD_W-1:0] o_word_value;
    logic              o_checksum_ok;
    logic              o_last_word;

    // frame decoder state, mirrors what the block must hold
    logic              in_frame;
    int unsigned       byte_pos;
    logic [15:0]       run_sum;
    logic [7:0]        hold_byte;
    logic [15:0]       word_mem [STORE_DEPTH];

    // words the decoder has produced and the block has not yet delivered
    t_frame_word       pending_words [$];

    int                mismatches;
    int                frames_sent;
    int                tx_idle_pct;
    int                rx_idle_pct;

    sensor_frame_checksum_parser_unit #(
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_word_index  (o_word_index),
        .o_word_value  (o_word_value),
        .o_checksum_ok (o_checksum_ok),
        .o_last_word   (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: a run that hangs is reported as a failure
    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    // decode one accepted byte; on the last frame byte queue the frame words
    function automatic void parse_byte(input logic [7:0] b);
        int unsigned p;
        int unsigned k;
        logic [15:0] rx_sum;
        t_frame_word w;
        if (!in_frame) begin
            // hunting: only the start byte opens a frame
            if (b == START_BYTE) begin
                in_frame = 1'b1;
                run_sum  = 16'(b);
                byte_pos = 1;
            end
            return;
        end
        p = byte_pos;
        // every byte but the checksum pair goes into the wrapping sum
        if (p + 2 < FRAME_BYTES) begin
            run_sum = run_sum + 16'(b);
        end
        if (p >= 2 && p + 3 <= FRAME_BYTES) begin
            if (((p - 2) & 1) == 0) begin
                hold_byte = b;
            end else begin
                k = (p - 3) >> 1;
                if (k < STORE_DEPTH) begin
                    word_mem[k] = {hold_byte, b};
                end
            end
        end else if (p + 2 == FRAME_BYTES) begin
            // high byte of the received checksum
            hold_byte = b;
        end
        if (p < FRAME_BYTES - 1) begin
            byte_pos = p + 1;
            return;
        end
        rx_sum = {hold_byte, b};
        for (k = 0; k < WORD_COUNT; k++) begin
            w.idx    = IDX_W'(k);
            w.value  = word_mem[k];
            w.sum_ok = (rx_sum == run_sum);
            w.last   = (k + 1 == WORD_COUNT);
            pending_words.push_back(w);
        end
        in_frame  = 1'b0;
        byte_pos  = 0;
        run_sum   = '0;
        hold_byte = '0;
    endfunction

    // receiver side: random stall, then check each word taken
    always @(posedge i_clk) begin
        i_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_frame_word exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_words.size() == 0) begin
                note_mismatch($sformatf("unexpected word idx %0d value %h",
                                        o_word_index, o_word_value));
            end else begin
                exp_w = pending_words.pop_front();
                if (o_word_index !== exp_w.idx || o_word_value !== exp_w.value ||
                    o_checksum_ok !== exp_w.sum_ok || o_last_word !== exp_w.last) begin
                    note_mismatch($sformatf(
                        "exp idx %0d val %h ok %0b last %0b, got idx %0d val %h ok %0b last %0b",
                        exp_w.idx, exp_w.value, exp_w.sum_ok, exp_w.last,
                        o_word_index, o_word_value, o_checksum_ok, o_last_word));
                end
            end
        end
    end

    // one transaction on the byte channel; valid stays high between back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        parse_byte(b);
    endtask

    // build and send one frame; the checksum is right unless good_sum is 0
    task automatic send_frame(input logic [7:0] second, input logic [15:0] length_word,
                              input bit good_sum, input bit extreme_data);
        logic [7:0]  fb [FRAME_BYTES];
        logic [15:0] sum;
        fb[0] = START_BYTE;
        fb[1] = second;
        fb[2] = length_word[15:8];
        fb[3] = length_word[7:0];
        for (int i = 4; i < FRAME_BYTES - 2; i++) begin
            // extreme data: words alternate all-zero and all-one
            fb[i] = extreme_data ? (((i / 2) % 2) ? 8'hFF : 8'h00) : 8'($urandom);
        end
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 2; i++) begin
            sum = sum + 16'(fb[i]);
        end
        if (!good_sum) begin
            sum = sum ^ 16'($urandom_range(1, 65535));
        end
        fb[FRAME_BYTES-2] = sum[15:8];
        fb[FRAME_BYTES-1] = sum[7:0];
        for (int i = 0; i < FRAME_BYTES; i++) begin
            send_byte(fb[i]);
        end
        frames_sent++;
    endtask

    // hold the sender off until every queued word has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    // non-start bytes while hunting, extreme bit patterns and near misses
    task automatic test_hunt_drop();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(8'h43);
        send_byte(8'hC2);
        send_byte(~START_BYTE);
    endtask

    // good checksum, second byte that is not the usual one, all-zero / all-one words
    task automatic test_extreme_frame();
        send_frame(8'h00, 16'(FRAME_BYTES - 4), 1'b1, 1'b1);
    endtask

    // noise runs between frames with random content; some checksums broken
    task automatic test_random_frames(input int budget);
        int sent;
        int n_noise;
        logic [7:0] second;
        logic [15:0] length_word;
        bit good_sum;
        sent = 0;
        while (sent < budget) begin
            n_noise = $urandom_range(0, 3);
            for (int i = 0; i < n_noise; i++) begin
                send_byte(8'($urandom));
            end
            second      = ($urandom_range(0, 3) != 0) ? SECOND_BYTE : 8'($urandom);
            length_word = ($urandom_range(0, 4) != 0) ? 16'(FRAME_BYTES - 4) :
                          16'($urandom);
            // every third frame gets a broken checksum, others now and then
            good_sum    = !((frames_sent % 3 == 1) || ($urandom_range(0, 7) == 0));
            send_frame(second, length_word, good_sum, 1'b0);
            sent += n_noise + FRAME_BYTES;
        end
    endtask

    initial begin
        in_frame    = 1'b0;
        byte_pos    = 0;
        run_sum     = '0;
        hold_byte   = '0;
        foreach (word_mem[i]) word_mem[i] = '0;
        mismatches  = 0;
        frames_sent = 0;
        tx_idle_pct = 7;
        rx_idle_pct = 56;

        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_byte <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: sender mostly busy, receiver stalls often
        test_hunt_drop();
        test_extreme_frame();
        wait_drained();
        test_random_frames(30);
        wait_drained();

        // phase 2: sender gaps often, receiver mostly ready
        tx_idle_pct = 56;
        rx_idle_pct = 7;
        test_random_frames(30);
        wait_drained();

        // phase 3: full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_frames(30);
        wait_drained();

        // let any stray word show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            note_mismatch($sformatf("%0d words never delivered", pending_words.size()));
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
